>>> rtl/hcq_pkg.sv
// Package for the hierarchical calendar queue scheduler.
// Holds the word types, status, level and register codes shared by all files.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hcq_pkg;

    typedef struct packed {
        logic        kind;
        logic [5:0]  flow_id;
        logic [15:0] packet_tag;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_tag;
        logic [31:0] round_now;
    } out_word_t;

    localparam logic KIND_ENQ = 1'b0;

    localparam logic [1:0] STAT_QUEUED   = 2'd0;
    localparam logic [1:0] STAT_DROPPED  = 2'd1;
    localparam logic [1:0] STAT_DEQUEUED = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    localparam logic [1:0] LV_A   = 2'd0;
    localparam logic [1:0] LV_B   = 2'd1;
    localparam logic [1:0] LV_ONE = 2'd2;
    localparam logic [1:0] LV_DEC = 2'd3;

    localparam logic [2:0] CFG_BURST = 3'd0;
    localparam logic [2:0] CFG_W0    = 3'd1;
    localparam logic [2:0] CFG_W1    = 3'd2;
    localparam logic [2:0] CFG_W2    = 3'd3;
    localparam logic [2:0] CFG_W3    = 3'd4;

    // Numerator width of the shared divider.
    localparam int DIV_NUM_W = 17;

endpackage
`default_nettype wire

>>> rtl/hcq_div.sv
// Shared restoring divider: one quotient bit per cycle.
// Depends on hcq_pkg for the numerator width.
`timescale 1ns / 1ps
`default_nettype none
module hcq_div
    import hcq_pkg::*;
#(
    parameter int DW = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DW-1:0]        den,
    output logic                      done,
    output logic [DIV_NUM_W-1:0]      quo
);
    localparam int KW = $clog2(DIV_NUM_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [KW-1:0]        step_reg, step_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        den_reg, den_next;
    logic [DW:0]          trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[DIV_NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = DW'(trial);
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            step_next = KW'(32'(step_reg) + 1);
            if (32'(step_reg) == DIV_NUM_W - 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

>>> rtl/hierarchical_calendar_queue_scheduler_core.sv
// Top level of the hierarchical calendar queue scheduler: sequencer, memories, config.
// Depends on hcq_pkg and hcq_div.
`timescale 1ns / 1ps
`default_nettype none
// One word is handled at a time. After reset the block first clears its flow table and
// FIFO count table before taking a word. An enqueue goes from its accept through flow
// read, departure and burst check, decade split through a constant table, FIFO count
// read, push and result before the next accept. A dequeue that finds a tag already
// waiting pops it, and one with nothing pending reports empty. Otherwise it walks up to
// FIFOS_PER_LEVEL^2 + 2*FIFOS_PER_LEVEL rounds, moving tags into the round buffer and
// using the shared divider when the level-one FIFO needs its ceiling division, then pops
// a tag or reports empty. A finished result waits in an output register, so the next
// word is accepted while it is still stalled.
module hierarchical_calendar_queue_scheduler_core
    import hcq_pkg::*;
#(
    parameter int FIFOS_PER_LEVEL = 10,
    parameter int STEP_DOWN_SLOT  = 9,
    parameter int FLOW_COUNT      = 64,
    parameter int FIFO_DEPTH      = 16,
    parameter int TAG_BITS        = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire in_word_t  req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output out_word_t      rsp,
    input  wire logic      cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int F     = FIFOS_PER_LEVEL;
    localparam int D     = FIFO_DEPTH;
    localparam int SW    = $clog2(F);
    localparam int DW    = $clog2(F + 1);
    localparam int HW    = $clog2(D);
    localparam int CW    = $clog2(D + 1);
    localparam int NFIFO = 4 * F;
    localparam int MW    = $clog2(NFIFO);
    localparam int SDEP  = NFIFO * D;
    localparam int SAW   = $clog2(SDEP);
    localparam int FW    = $clog2(FLOW_COUNT);
    localparam int BUF   = 2 * D;
    localparam int BW    = $clog2(BUF);
    localparam int BCW   = $clog2(BUF + 1);
    localparam int WALK  = F * F + 2 * F;
    localparam int WW    = $clog2(WALK + 1);
    localparam int CLR_N = (FLOW_COUNT > NFIFO) ? FLOW_COUNT : NFIFO;
    localparam int CLW   = $clog2(CLR_N);
    localparam int SQ    = F * F;
    localparam int TW    = $clog2(SQ);

    typedef enum logic [16:0] {
        S_CLEAR    = 17'h00001,
        S_IDLE     = 17'h00002,
        S_ENQ_FLOW = 17'h00004,
        S_ENQ_DIV  = 17'h00008,
        S_ENQ_MREQ = 17'h00010,
        S_ENQ_PUSH = 17'h00020,
        S_RND_UP   = 17'h00040,
        S_MREQ     = 17'h00080,
        S_DLOAD    = 17'h00100,
        S_CDIV     = 17'h00200,
        S_CHK      = 17'h00400,
        S_RD       = 17'h00800,
        S_PH_END   = 17'h01000,
        S_RND_END  = 17'h02000,
        S_POP1     = 17'h04000,
        S_POP2     = 17'h08000,
        S_FIN      = 17'h10000
    } state_t;

    // Configuration registers.
    logic [15:0] burst_reg;
    logic [7:0]  w0_reg, w1_reg, w2_reg, w3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg <= 16'd1000;
            w0_reg    <= 8'd1;
            w1_reg    <= 8'd2;
            w2_reg    <= 8'd3;
            w3_reg    <= 8'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BURST: burst_reg <= cfg_data;
                CFG_W0:    w0_reg    <= cfg_data[7:0];
                CFG_W1:    w1_reg    <= cfg_data[7:0];
                CFG_W2:    w2_reg    <= cfg_data[7:0];
                CFG_W3:    w3_reg    <= cfg_data[7:0];
                default:   ;
            endcase
        end
    end

    // Flow id to table row.
    logic [FW-1:0] fmod_tab [64];
    for (genvar g = 0; g < 64; g++)
    begin : g_fmod
        assign fmod_tab[g] = FW'(g % FLOW_COUNT);
    end

    // Decade and slot of an offset that lies less than F decades ahead.
    logic [SW-1:0] sq_tab [SQ];
    logic [SW-1:0] sr_tab [SQ];
    for (genvar g = 0; g < SQ; g++)
    begin : g_split
        assign sq_tab[g] = SW'(g / F);
        assign sr_tab[g] = SW'(g % F);
    end

    // Control registers.
    state_t          state_reg, state_next;
    logic [31:0]     vr_reg, vr_next;
    logic [31:0]     vr_dec_reg, vr_dec_next;
    logic [SW-1:0]   vr_mod_reg, vr_mod_next;
    logic [SW-1:0]   vr_dm_reg, vr_dm_next;
    logic [15:0]     pend_reg, pend_next;
    logic [SW-1:0]   li_a_reg, li_a_next, li_b_reg, li_b_next;
    logic [SW-1:0]   li_one_reg, li_one_next, li_dec_reg, li_dec_next;
    logic [BW-1:0]   bh_reg, bh_next;
    logic [BCW-1:0]  bc_reg, bc_next;
    logic [CLW-1:0]  clr_reg, clr_next;
    logic [WW-1:0]   walk_reg, walk_next;
    logic            up_phase_reg, up_phase_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // Working registers.
    logic [FW-1:0]       flow_idx_reg, flow_idx_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [7:0]          wgt_reg, wgt_next;
    logic [31:0]         dep_reg, dep_next;
    logic [16:0]         split_reg, split_next;
    logic [1:0]          lv_reg, lv_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic                nup_reg, nup_next;
    logic                ceil_reg, ceil_next;
    logic [CW-1:0]       wk_cnt_reg, wk_cnt_next;
    logic [HW-1:0]       wk_head_reg, wk_head_next;
    logic [CW-1:0]       wk_n_reg, wk_n_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [15:0]         res_tag_reg, res_tag_next;
    out_word_t           rsp_reg, rsp_next;

    // Memories.
    logic [32:0]         flow_mem [FLOW_COUNT];
    logic [32:0]         flow_rdata_reg;
    logic                flow_we;
    logic [FW-1:0]       flow_waddr;
    logic [32:0]         flow_wdata;

    logic [CW+HW-1:0]    meta_mem [NFIFO];
    logic [CW+HW-1:0]    meta_rdata_reg;
    logic                meta_we;
    logic [MW-1:0]       meta_waddr;
    logic [CW+HW-1:0]    meta_wdata;
    logic [MW-1:0]       meta_idx;

    logic [TAG_BITS-1:0] store_mem [SDEP];
    logic [TAG_BITS-1:0] store_rdata_reg;
    logic                store_we;
    logic [SAW-1:0]      store_waddr, store_raddr;

    logic [TAG_BITS-1:0] rbuf_mem [BUF];
    logic [TAG_BITS-1:0] rbuf_rdata_reg;
    logic                rbuf_we;
    logic [BW-1:0]       rbuf_waddr;

    always_ff @(posedge clk)
    begin
        if (flow_we)
        begin
            flow_mem[flow_waddr] <= flow_wdata;
        end
        flow_rdata_reg <= flow_mem[fmod_tab[req.flow_id]];
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rdata_reg <= meta_mem[meta_idx];
        if (store_we)
        begin
            store_mem[store_waddr] <= tag_reg;
        end
        store_rdata_reg <= store_mem[store_raddr];
        if (rbuf_we)
        begin
            rbuf_mem[rbuf_waddr] <= store_rdata_reg;
        end
        rbuf_rdata_reg <= rbuf_mem[bh_reg];
    end

    // Shared divider.
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DW-1:0]        div_den;

    hcq_div #(
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    logic            accept;
    logic [CW-1:0]   m_cnt;
    logic [HW-1:0]   m_head;
    logic [31:0]     last_dep, start_rnd, dep_calc, diff;
    logic [31:0]     dm_sum, pos_sum, wb_sum, li_adv, head_adv;
    logic [DW-1:0]   d_left;
    logic [SW-1:0]   lo_slot;
    logic [1:0]      lo_lv;
    logic [31:0]     tag32;
    logic [SW-1:0]   sp_quo, sp_rem;

    assign accept   = req_valid && !req_stall;
    assign m_cnt    = meta_rdata_reg[CW+HW-1:HW];
    assign m_head   = meta_rdata_reg[HW-1:0];
    assign meta_idx = MW'(32'(lv_reg) * F + 32'(slot_reg));
    assign store_raddr = SAW'(32'(meta_idx) * D + 32'(wk_head_reg));
    assign d_left   = DW'(32'(F) - 32'(vr_mod_reg));
    assign lo_lv    = vr_dec_reg[0] ? LV_B : LV_A;
    assign lo_slot  = vr_dec_reg[0] ? li_b_reg : li_a_reg;
    assign sp_quo   = sq_tab[split_reg[TW-1:0]];
    assign sp_rem   = sr_tab[split_reg[TW-1:0]];

    always_comb
    begin
        state_next      = state_reg;
        vr_next         = vr_reg;
        vr_dec_next     = vr_dec_reg;
        vr_mod_next     = vr_mod_reg;
        vr_dm_next      = vr_dm_reg;
        pend_next       = pend_reg;
        li_a_next       = li_a_reg;
        li_b_next       = li_b_reg;
        li_one_next     = li_one_reg;
        li_dec_next     = li_dec_reg;
        bh_next         = bh_reg;
        bc_next         = bc_reg;
        clr_next        = clr_reg;
        walk_next       = walk_reg;
        up_phase_next   = up_phase_reg;
        rsp_valid_next  = rsp_valid_reg;
        flow_idx_next   = flow_idx_reg;
        tag_next        = tag_reg;
        wgt_next        = wgt_reg;
        dep_next        = dep_reg;
        split_next      = split_reg;
        lv_next         = lv_reg;
        slot_next       = slot_reg;
        nup_next        = nup_reg;
        ceil_next       = ceil_reg;
        wk_cnt_next     = wk_cnt_reg;
        wk_head_next    = wk_head_reg;
        wk_n_next       = wk_n_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        rsp_next        = rsp_reg;

        flow_we     = 1'b0;
        flow_waddr  = flow_idx_reg;
        flow_wdata  = {nup_reg, dep_reg};
        meta_we     = 1'b0;
        meta_waddr  = meta_idx;
        meta_wdata  = {wk_cnt_reg, wk_head_reg};
        store_we    = 1'b0;
        rbuf_we     = 1'b0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = DW'(F);

        last_dep  = flow_rdata_reg[31:0];
        start_rnd = (last_dep > vr_reg) ? last_dep : vr_reg;
        dep_calc  = start_rnd + 32'(wgt_reg);
        if (dep_calc < vr_reg)
        begin
            dep_calc = vr_reg;
        end
        diff = dep_calc - vr_reg;

        dm_sum = 32'(vr_dm_reg) + 32'(sp_quo);
        if (dm_sum >= F)
        begin
            dm_sum = dm_sum - F;
        end
        pos_sum = 32'(m_head) + 32'(m_cnt);
        if (pos_sum >= D)
        begin
            pos_sum = pos_sum - D;
        end
        store_waddr = SAW'(32'(meta_idx) * D + pos_sum);
        wb_sum = 32'(bh_reg) + 32'(bc_reg);
        if (wb_sum >= BUF)
        begin
            wb_sum = wb_sum - BUF;
        end
        rbuf_waddr = BW'(wb_sum);
        li_adv = 32'(lo_slot) + 1;
        if (li_adv == F)
        begin
            li_adv = 32'd0;
        end
        head_adv = 32'(wk_head_reg) + 1;
        if (head_adv == D)
        begin
            head_adv = 32'd0;
        end
        tag32 = {16'd0, req.packet_tag};

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                flow_we    = 32'(clr_reg) < FLOW_COUNT;
                flow_waddr = FW'(clr_reg);
                flow_wdata = '0;
                meta_we    = 32'(clr_reg) < NFIFO;
                meta_waddr = MW'(clr_reg);
                meta_wdata = '0;
                clr_next   = CLW'(32'(clr_reg) + 1);
                if (32'(clr_reg) == CLR_N - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    flow_idx_next = fmod_tab[req.flow_id];
                    tag_next      = TAG_BITS'(tag32);
                    unique case (req.flow_id[1:0])
                        2'd0: wgt_next = w0_reg;
                        2'd1: wgt_next = w1_reg;
                        2'd2: wgt_next = w2_reg;
                        2'd3: wgt_next = w3_reg;
                        default: wgt_next = w3_reg;
                    endcase
                    res_tag_next = '0;
                    if (req.kind == KIND_ENQ)
                    begin
                        state_next = S_ENQ_FLOW;
                    end
                    else if (pend_reg == '0)
                    begin
                        res_status_next = STAT_EMPTY;
                        state_next      = S_FIN;
                    end
                    else if (bc_reg != '0)
                    begin
                        state_next = S_POP1;
                    end
                    else
                    begin
                        walk_next  = '0;
                        state_next = S_RND_UP;
                    end
                end
            end
            S_ENQ_FLOW:
            begin
                if (diff >= 32'(burst_reg))
                begin
                    res_status_next = STAT_DROPPED;
                    state_next      = S_FIN;
                end
                else
                begin
                    nup_next   = flow_rdata_reg[32];
                    dep_next   = dep_calc;
                    split_next = 17'(32'(vr_mod_reg) + 32'(diff[15:0]));
                    state_next = S_ENQ_DIV;
                end
            end
            S_ENQ_DIV:
            begin
                // The departure lies F decades or more ahead.
                if (32'(split_reg) >= SQ)
                begin
                    res_status_next = STAT_DROPPED;
                    state_next      = S_FIN;
                end
                else
                begin
                    if (32'(sp_quo) > 1 || nup_reg)
                    begin
                        if (dm_sum == STEP_DOWN_SLOT)
                        begin
                            lv_next   = LV_DEC;
                            slot_next = sp_rem;
                            nup_next  = 1'b0;
                        end
                        else
                        begin
                            lv_next   = LV_ONE;
                            slot_next = SW'(dm_sum);
                            nup_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        lv_next   = (vr_dec_reg[0] ^ sp_quo[0]) ? LV_B : LV_A;
                        slot_next = sp_rem;
                        nup_next  = 1'b0;
                    end
                    state_next = S_ENQ_MREQ;
                end
            end
            S_ENQ_MREQ:
            begin
                state_next = S_ENQ_PUSH;
            end
            S_ENQ_PUSH:
            begin
                if (32'(m_cnt) >= D)
                begin
                    res_status_next = STAT_DROPPED;
                end
                else
                begin
                    store_we        = 1'b1;
                    meta_we         = 1'b1;
                    meta_wdata      = {CW'(32'(m_cnt) + 1), m_head};
                    flow_we         = 1'b1;
                    pend_next       = pend_reg + 16'd1;
                    res_status_next = STAT_QUEUED;
                end
                state_next = S_FIN;
            end
            S_RND_UP:
            begin
                up_phase_next = 1'b1;
                if (32'(vr_dm_reg) == STEP_DOWN_SLOT)
                begin
                    lv_next   = LV_DEC;
                    slot_next = li_dec_reg;
                    ceil_next = 1'b0;
                    wk_n_next = CW'(D);
                end
                else
                begin
                    lv_next   = LV_ONE;
                    slot_next = li_one_reg;
                    ceil_next = 1'b1;
                end
                state_next = S_MREQ;
            end
            S_MREQ:
            begin
                state_next = S_DLOAD;
            end
            S_DLOAD:
            begin
                wk_cnt_next  = m_cnt;
                wk_head_next = m_head;
                if (!ceil_reg)
                begin
                    state_next = S_CHK;
                end
                else if (m_cnt == '0)
                begin
                    state_next = S_PH_END;
                end
                else
                begin
                    // Ceiling of count over the rounds left in this decade.
                    div_start  = 1'b1;
                    div_num    = DIV_NUM_W'(32'(m_cnt) + 32'(d_left) - 1);
                    div_den    = d_left;
                    state_next = S_CDIV;
                end
            end
            S_CDIV:
            begin
                div_den = d_left;
                if (div_done)
                begin
                    wk_n_next  = CW'(div_quo);
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (wk_n_reg != '0 && wk_cnt_reg != '0 && 32'(bc_reg) < BUF)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    meta_we    = 1'b1;
                    state_next = S_PH_END;
                end
            end
            S_RD:
            begin
                rbuf_we      = 1'b1;
                bc_next      = BCW'(32'(bc_reg) + 1);
                wk_head_next = HW'(head_adv);
                wk_cnt_next  = wk_cnt_reg - CW'(1);
                wk_n_next    = wk_n_reg - CW'(1);
                state_next   = S_CHK;
            end
            S_PH_END:
            begin
                if (up_phase_reg)
                begin
                    if (lv_reg == LV_DEC)
                    begin
                        li_dec_next = (32'(li_dec_reg) + 1 == F) ? '0
                                    : SW'(32'(li_dec_reg) + 1);
                    end
                    up_phase_next = 1'b0;
                    lv_next       = lo_lv;
                    slot_next     = lo_slot;
                    ceil_next     = 1'b0;
                    wk_n_next     = CW'(D);
                    state_next    = S_MREQ;
                end
                else
                begin
                    if (vr_dec_reg[0])
                    begin
                        li_b_next = SW'(li_adv);
                    end
                    else
                    begin
                        li_a_next = SW'(li_adv);
                    end
                    // Level zero wrapped: move level one to its next slot.
                    if (li_adv == 32'd0)
                    begin
                        li_one_next = (32'(li_one_reg) + 1 == F) ? '0
                                    : SW'(32'(li_one_reg) + 1);
                    end
                    state_next = S_RND_END;
                end
            end
            S_RND_END:
            begin
                vr_next = vr_reg + 32'd1;
                if (vr_reg == 32'hFFFF_FFFF)
                begin
                    vr_dec_next = '0;
                    vr_mod_next = '0;
                    vr_dm_next  = '0;
                end
                else if (32'(vr_mod_reg) + 1 == F)
                begin
                    vr_mod_next = '0;
                    vr_dec_next = vr_dec_reg + 32'd1;
                    vr_dm_next  = (32'(vr_dm_reg) + 1 == F) ? '0
                                : SW'(32'(vr_dm_reg) + 1);
                end
                else
                begin
                    vr_mod_next = SW'(32'(vr_mod_reg) + 1);
                end
                walk_next = WW'(32'(walk_reg) + 1);
                if (bc_reg == '0 && 32'(walk_reg) + 1 < WALK)
                begin
                    state_next = S_RND_UP;
                end
                else if (bc_reg == '0)
                begin
                    res_status_next = STAT_EMPTY;
                    state_next      = S_FIN;
                end
                else
                begin
                    state_next = S_POP1;
                end
            end
            S_POP1:
            begin
                state_next = S_POP2;
            end
            S_POP2:
            begin
                res_tag_next    = 16'(32'(rbuf_rdata_reg));
                res_status_next = STAT_DEQUEUED;
                bh_next         = (32'(bh_reg) + 1 == BUF) ? '0 : BW'(32'(bh_reg) + 1);
                bc_next         = bc_reg - BCW'(1);
                pend_next       = pend_reg - 16'd1;
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status    = res_status_reg;
                    rsp_next.out_tag   = res_tag_reg;
                    rsp_next.round_now = vr_reg;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            vr_reg        <= '0;
            vr_dec_reg    <= '0;
            vr_mod_reg    <= '0;
            vr_dm_reg     <= '0;
            pend_reg      <= '0;
            li_a_reg      <= '0;
            li_b_reg      <= '0;
            li_one_reg    <= '0;
            li_dec_reg    <= '0;
            bh_reg        <= '0;
            bc_reg        <= '0;
            clr_reg       <= '0;
            walk_reg      <= '0;
            up_phase_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vr_reg        <= vr_next;
            vr_dec_reg    <= vr_dec_next;
            vr_mod_reg    <= vr_mod_next;
            vr_dm_reg     <= vr_dm_next;
            pend_reg      <= pend_next;
            li_a_reg      <= li_a_next;
            li_b_reg      <= li_b_next;
            li_one_reg    <= li_one_next;
            li_dec_reg    <= li_dec_next;
            bh_reg        <= bh_next;
            bc_reg        <= bc_next;
            clr_reg       <= clr_next;
            walk_reg      <= walk_next;
            up_phase_reg  <= up_phase_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flow_idx_reg   <= flow_idx_next;
        tag_reg        <= tag_next;
        wgt_reg        <= wgt_next;
        dep_reg        <= dep_next;
        split_reg      <= split_next;
        lv_reg         <= lv_next;
        slot_reg       <= slot_next;
        nup_reg        <= nup_next;
        ceil_reg       <= ceil_next;
        wk_cnt_reg     <= wk_cnt_next;
        wk_head_reg    <= wk_head_next;
        wk_n_reg       <= wk_n_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        rsp_reg        <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bc_reg) <= BUF)
        else $error("round buffer count exceeds its size");

    a_round_split: assert property (@(posedge clk) disable iff (!rst_n)
        32'(vr_mod_reg) < F && 32'(vr_dm_reg) < F)
        else $error("round remainder or decade slot out of range");

    a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RND_END |=> vr_reg == $past(vr_reg) + 32'd1)
        else $error("virtual round did not advance by one");

endmodule
`default_nettype wire
